// ----- rtl/ct_pkg.sv -----
// Shared types and constants for the command line tokenizer.
// Scan modes, result kinds, the result run record and byte class helpers.
// No dependencies.
`default_nettype none

package ct_pkg;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_IGNORE  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOL  = 2'd2
    } kind_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam int RUN_DEPTH = 4;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [10:0] count;
    } result_t;

    typedef struct packed {
        logic [2:0]    n;
        result_t [3:0] items;
    } run_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c <= CH_SPACE) || (c >= CH_HIGH);
    endfunction

    // append one result to a run; extra results past the run depth are dropped
    function automatic run_t push(input run_t r, input kind_t k, input logic [7:0] b,
                                  input logic [10:0] cnt);
        run_t o;
        o = r;
        if (r.n < 3'(RUN_DEPTH))
        begin
            o.items[r.n[1:0]].kind  = k;
            o.items[r.n[1:0]].data  = (k == KIND_BYTE) ? b : 8'h00;
            o.items[r.n[1:0]].count = cnt;
            o.n = r.n + 3'd1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ct_step.sv -----
// Scan state and per-byte update of the command line tokenizer.
// Depends on ct_pkg; produces one run of up to four results per accepted byte.
`default_nettype none

module ct_step
    import ct_pkg::*;
#(
    parameter int LIMIT_CAP = 1024,
    parameter int CNT_W     = 11
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    input  wire logic [10:0] max_tokens,
    output run_t             run
);

    typedef struct packed {
        mode_t       mode;
        logic        slash;
        logic        star;
        logic [10:0] count;
        run_t        run;
    } step_t;

    mode_t             mode_reg,  mode_next;
    logic              slash_reg, slash_next;
    logic              star_reg,  star_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [10:0]       limit;
    step_t             stp;

    assign limit = (max_tokens < 11'(LIMIT_CAP)) ? max_tokens : 11'(LIMIT_CAP);

    function automatic step_t scan(input mode_t m0, input logic sp0, input logic ss0,
                                   input logic [10:0] tf0, input logic [7:0] c,
                                   input logic lst, input logic [10:0] lim);
        mode_t       m;
        logic        sp;
        logic        ss;
        logic [10:0] tf;
        run_t        r;
        logic        do_plain;
        logic        do_between;
        step_t       o;
        m = m0;
        sp = sp0;
        ss = ss0;
        tf = tf0;
        r = '0;
        do_plain = 1'b0;
        do_between = 1'b0;
        if (sp)
        begin
            sp = 1'b0;
            if (m == MODE_PLAIN)
            begin
                if (c == CH_SLASH)
                begin
                    r = push(r, KIND_END, 8'h00, tf);
                    m = MODE_IGNORE;
                end
                else if (c == CH_STAR)
                begin
                    r = push(r, KIND_END, 8'h00, tf);
                    if (tf >= lim)
                        m = MODE_IGNORE;
                    else
                    begin
                        m = MODE_COMMENT;
                        ss = 1'b1;
                    end
                end
                else
                begin
                    r = push(r, KIND_BYTE, CH_SLASH, tf);
                    do_plain = 1'b1;
                end
            end
            else
            begin
                if (c == CH_SLASH)
                    m = MODE_IGNORE;
                else if (c == CH_STAR)
                begin
                    m = MODE_COMMENT;
                    ss = 1'b1;
                end
                else
                begin
                    tf = tf + 11'd1;
                    m = MODE_PLAIN;
                    r = push(r, KIND_BYTE, CH_SLASH, tf);
                    do_plain = 1'b1;
                end
            end
        end
        else
        begin
            case (m)
                MODE_BETWEEN: do_between = 1'b1;
                MODE_PLAIN:   do_plain = 1'b1;
                MODE_QUOTED:
                begin
                    if (c == CH_QUOTE)
                    begin
                        r = push(r, KIND_END, 8'h00, tf);
                        m = MODE_BETWEEN;
                    end
                    else
                        r = push(r, KIND_BYTE, c, tf);
                end
                MODE_COMMENT:
                begin
                    if (c == CH_SLASH && ss)
                    begin
                        ss = 1'b0;
                        m = MODE_BETWEEN;
                    end
                    else
                        ss = (c == CH_STAR);
                end
                default: ;
            endcase
        end

        if (do_plain)
        begin
            if (is_sep(c))
            begin
                r = push(r, KIND_END, 8'h00, tf);
                m = MODE_BETWEEN;
            end
            else if (c == CH_QUOTE)
            begin
                r = push(r, KIND_END, 8'h00, tf);
                m = MODE_BETWEEN;
                do_between = 1'b1;
            end
            else if (c == CH_SLASH)
                sp = 1'b1;
            else
                r = push(r, KIND_BYTE, c, tf);
        end

        if (do_between)
        begin
            if (tf >= lim)
                m = MODE_IGNORE;
            else if (!is_sep(c))
            begin
                if (c == CH_QUOTE)
                begin
                    tf = tf + 11'd1;
                    m = MODE_QUOTED;
                end
                else if (c == CH_SLASH)
                    sp = 1'b1;
                else
                begin
                    tf = tf + 11'd1;
                    m = MODE_PLAIN;
                    r = push(r, KIND_BYTE, c, tf);
                end
            end
        end

        // end of line: flush a held slash, close an open token, report the count
        if (lst)
        begin
            if (sp)
            begin
                sp = 1'b0;
                if (m != MODE_PLAIN)
                begin
                    tf = tf + 11'd1;
                    m = MODE_PLAIN;
                end
                r = push(r, KIND_BYTE, CH_SLASH, tf);
            end
            if (m == MODE_PLAIN || m == MODE_QUOTED)
                r = push(r, KIND_END, 8'h00, tf);
            r = push(r, KIND_EOL, 8'h00, tf);
            m = MODE_BETWEEN;
            ss = 1'b0;
            tf = 11'd0;
        end

        o.mode = m;
        o.slash = sp;
        o.star = ss;
        o.count = tf;
        o.run = r;
        return o;
    endfunction

    assign stp = scan(mode_reg, slash_reg, star_reg, 11'(count_reg), ch, last, limit);

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        count_next = count_reg;
        if (load)
        begin
            mode_next  = stp.mode;
            slash_next = stp.slash;
            star_next  = stp.star;
            count_next = CNT_W'(stp.count);
        end
    end

    // outputs
    always_comb
    begin
        run = stp.run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ct_outq.sv -----
// Result run register of the command line tokenizer.
// Depends on ct_pkg; holds one run of results and hands them out one beat each.
`default_nettype none

module ct_outq
    import ct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire run_t run_in,
    input  wire logic out_ready,
    output logic      out_valid,
    output result_t   item,
    output logic      item_last,
    output logic      can_load
);

    result_t [3:0] items_reg;
    logic [1:0]    head_reg, head_next;
    logic [2:0]    left_reg, left_next;
    logic          pop;

    assign out_valid = (left_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign item      = items_reg[head_reg];
    assign item_last = (left_reg == 3'd1);
    // a new run may land as the final result of the current one leaves
    assign can_load  = (left_reg == 3'd0) || (left_reg == 3'd1 && out_ready);

    always_comb
    begin
        head_next = head_reg;
        left_next = left_reg;
        if (load)
        begin
            head_next = 2'd0;
            left_next = run_in.n;
        end
        else if (pop)
        begin
            head_next = head_reg + 2'd1;
            left_next = left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= run_in.items;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 2'd0;
            left_reg <= 3'd0;
        end
        else
        begin
            head_reg <= head_next;
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/command_line_tokenizer.sv -----
// Top level of the command line tokenizer: APB register, scan stage, result run register.
// Depends on ct_pkg, ct_step and ct_outq.
`default_nettype none

// Command line tokenizer. Bytes of one command line enter on the input channel
// (ch, last) one beat each; the beat with last = 1 closes the line. Each byte
// is scanned in the cycle it is accepted: the scan state (mode, held slash,
// star flag, token count) updates at once and the results that byte causes,
// zero to four of them, are written as one run into the result register.
// Results leave on the output channel one beat each, carrying kind (token
// byte, end of token, end of line), token_byte, token_index, token_count and
// last_of_run on the final beat of the run. Bytes that yield no result or one
// result stream at one byte per clock while the output is ready; a byte with
// more results holds the input until its run is down to one, since the result
// register drains one result per output beat. The input takes a new byte in
// the same cycle the last result of the previous run is taken. Separators are
// bytes 0x00-0x20 and 0x80-0xFF; double quotes make a (possibly empty) quoted
// token; "//" drops the rest of the line; a block comment skips to its closing
// star-slash. A lone slash is held one byte to see what follows it. The token
// limit is max_tokens (APB offset 0x0, reset 1024), clamped to MAX_TOKENS; a
// limit of zero gives no tokens. Write max_tokens only while the block is idle.

module command_line_tokenizer
    import ct_pkg::*;
#(
    parameter int MAX_TOKENS = 1024
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       token_byte,
    output logic [9:0]       token_index,
    output logic [10:0]      token_count,
    output logic             last_of_run
);

    // the limit register is 11 bits, so the count never passes 2047
    localparam int LIMIT_CAP = (MAX_TOKENS < 2047) ? MAX_TOKENS : 2047;
    localparam int CNT_W     = $clog2(LIMIT_CAP + 1);

    localparam logic REG_MAX_TOKENS = 1'b0;

    logic [10:0] max_tokens_reg;
    logic        cfg_write;
    logic        in_beat;
    run_t        run;
    result_t     item;
    logic [10:0] index_full;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_TOKENS);
    assign prdata    = (paddr[2] == REG_MAX_TOKENS) ? {21'd0, max_tokens_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_tokens_reg <= 11'd1024;
        else if (cfg_write)
            max_tokens_reg <= pwdata[10:0];
    end

    // ---------------- scan stage ----------------
    assign in_beat = in_valid && in_ready;

    ct_step #(
        .LIMIT_CAP (LIMIT_CAP),
        .CNT_W     (CNT_W)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_beat),
        .ch         (ch),
        .last       (last),
        .max_tokens (max_tokens_reg),
        .run        (run)
    );

    // ---------------- result run register ----------------
    ct_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_beat),
        .run_in    (run),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .item      (item),
        .item_last (last_of_run),
        .can_load  (in_ready)
    );

    // token index is the count minus one for bytes and end marks, zero on end of line
    assign index_full  = item.count - 11'd1;
    assign kind        = item.kind;
    assign token_byte  = item.data;
    assign token_count = item.count;
    assign token_index = (item.kind == KIND_EOL || item.count == 11'd0) ? 10'd0
                                                                      : index_full[9:0];

    // ---------------- assertions ----------------
    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no results pending");

    // end of line is always the final result of its run
    a_eol_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_EOL) |-> last_of_run)
        else $error("end-of-line result not last in its run");

    // only token bytes carry data
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_BYTE) |-> (token_byte == 8'h00))
        else $error("nonzero byte on a mark result");

    // a stalled result holds while the input side waits on it
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !last_of_run) |=> (out_valid && !in_ready))
        else $error("run register lost a pending result");

endmodule

`default_nettype wire

// ----- verif/command_line_tokenizer_checker.sv -----
// Scoreboard for the command line tokenizer: watches the APB, byte and result channels,
// predicts the result beats of every accepted byte and compares them in order.
// Depends on ct_pkg for the scan mode and result kind enums and the byte constants.

module command_line_tokenizer_checker
    import ct_pkg::*;
#(
    parameter int         MAX_TOKENS = 1024,
    parameter logic [2:0] LIMIT_ADDR = 3'd0
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  token_byte,
    input  wire logic [9:0]  token_index,
    input  wire logic [10:0] token_count,
    input  wire logic        last_of_run,
    output int               beats_due,
    output int               fail_total
);

    localparam logic [10:0] LIMIT_RESET = 11'd1024;
    localparam int          PRINT_CAP   = 50;
    localparam int          RUN_MAX     = 4;

    typedef struct {
        kind_t       kind;
        logic [7:0]  tbyte;
        logic [9:0]  index;
        logic [10:0] count;
        logic        tail;
    } token_beat_t;

    // shadow of the block's register and scan state
    logic [10:0] limit_reg;
    mode_t       scan_mode;
    logic        slash_held;
    logic        star_last;
    logic [10:0] tokens;

    token_beat_t step_beats[$];
    token_beat_t token_beats_q[$];
    int          fail_count = 0;
    int          beat_no = 0;

    assign fail_total = fail_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("mismatch at result beat %0d: %s", beat_no, msg);
        fail_count++;
    endtask

    function automatic logic is_gap_byte(input logic [7:0] c);
        return (c <= 8'h20) || c[7];
    endfunction

    function automatic int limit_now();
        return (int'(limit_reg) < MAX_TOKENS) ? int'(limit_reg) : MAX_TOKENS;
    endfunction

    function automatic void emit(input kind_t k, input logic [7:0] b);
        token_beat_t e;
        if (step_beats.size() >= RUN_MAX)
            return;
        e.kind  = k;
        e.tbyte = (k == KIND_BYTE) ? b : 8'h00;
        e.index = (k != KIND_EOL && tokens != 11'd0) ? 10'(tokens - 11'd1) : 10'd0;
        e.count = tokens;
        e.tail  = 1'b0;
        step_beats.push_back(e);
    endfunction

    function automatic void between_byte(input logic [7:0] c);
        if (int'(tokens) >= limit_now())
        begin
            scan_mode = MODE_IGNORE;
            return;
        end
        if (is_gap_byte(c))
            return;
        if (c == CH_QUOTE)
        begin
            tokens = tokens + 11'd1;
            scan_mode = MODE_QUOTED;
        end
        else if (c == CH_SLASH)
            slash_held = 1'b1;
        else
        begin
            tokens = tokens + 11'd1;
            scan_mode = MODE_PLAIN;
            emit(KIND_BYTE, c);
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (is_gap_byte(c))
        begin
            emit(KIND_END, 8'h00);
            scan_mode = MODE_BETWEEN;
        end
        else if (c == CH_QUOTE)
        begin
            emit(KIND_END, 8'h00);
            scan_mode = MODE_BETWEEN;
            between_byte(c);
        end
        else if (c == CH_SLASH)
            slash_held = 1'b1;
        else
            emit(KIND_BYTE, c);
    endfunction

    // a held slash is resolved by the byte after it
    function automatic void resolve_slash(input logic [7:0] c);
        slash_held = 1'b0;
        if (scan_mode == MODE_PLAIN)
        begin
            if (c == CH_SLASH)
            begin
                emit(KIND_END, 8'h00);
                scan_mode = MODE_IGNORE;
            end
            else if (c == CH_STAR)
            begin
                emit(KIND_END, 8'h00);
                if (int'(tokens) >= limit_now())
                    scan_mode = MODE_IGNORE;
                else
                begin
                    scan_mode = MODE_COMMENT;
                    star_last = 1'b1;
                end
            end
            else
            begin
                emit(KIND_BYTE, CH_SLASH);
                plain_byte(c);
            end
        end
        else if (c == CH_SLASH)
            scan_mode = MODE_IGNORE;
        else if (c == CH_STAR)
        begin
            scan_mode = MODE_COMMENT;
            star_last = 1'b1;
        end
        else
        begin
            tokens = tokens + 11'd1;
            scan_mode = MODE_PLAIN;
            emit(KIND_BYTE, CH_SLASH);
            plain_byte(c);
        end
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        if (slash_held)
        begin
            resolve_slash(c);
            return;
        end
        case (scan_mode)
            MODE_BETWEEN: between_byte(c);
            MODE_PLAIN:   plain_byte(c);
            MODE_QUOTED:
            begin
                if (c == CH_QUOTE)
                begin
                    emit(KIND_END, 8'h00);
                    scan_mode = MODE_BETWEEN;
                end
                else
                    emit(KIND_BYTE, c);
            end
            MODE_COMMENT:
            begin
                if (c == CH_SLASH && star_last)
                begin
                    star_last = 1'b0;
                    scan_mode = MODE_BETWEEN;
                end
                else
                    star_last = (c == CH_STAR);
            end
            default: ;
        endcase
    endfunction

    function automatic void close_line();
        if (slash_held)
        begin
            slash_held = 1'b0;
            if (scan_mode != MODE_PLAIN)
            begin
                tokens = tokens + 11'd1;
                scan_mode = MODE_PLAIN;
            end
            emit(KIND_BYTE, CH_SLASH);
        end
        if (scan_mode == MODE_PLAIN || scan_mode == MODE_QUOTED)
            emit(KIND_END, 8'h00);
        emit(KIND_EOL, 8'h00);
        scan_mode = MODE_BETWEEN;
        star_last = 1'b0;
        tokens = 11'd0;
    endfunction

    // predict the run of result beats one accepted byte causes
    function automatic void scan_byte(input logic [7:0] c, input logic eol);
        step_beats.delete();
        take_byte(c);
        if (eol)
            close_line();
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].tail = 1'b1;
        foreach (step_beats[i])
            token_beats_q.push_back(step_beats[i]);
    endfunction

    task automatic check_beat();
        token_beat_t want;
        if (token_beats_q.size() == 0)
        begin
            report_mismatch($sformatf("kind %0d byte %02h with nothing outstanding",
                                      kind, token_byte));
            return;
        end
        want = token_beats_q.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (token_byte !== want.tbyte)
            report_mismatch($sformatf("token_byte %02h, want %02h", token_byte, want.tbyte));
        if (token_index !== want.index)
            report_mismatch($sformatf("token_index %0d, want %0d", token_index, want.index));
        if (token_count !== want.count)
            report_mismatch($sformatf("token_count %0d, want %0d", token_count, want.count));
        if (last_of_run !== want.tail)
            report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.tail));
    endtask

    // results leave before the byte taken at the same edge adds its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  = LIMIT_RESET;
            scan_mode  = MODE_BETWEEN;
            slash_held = 1'b0;
            star_last  = 1'b0;
            tokens     = 11'd0;
            token_beats_q.delete();
            beats_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_beat();
                beat_no++;
            end
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                limit_reg = pwdata[10:0];
            if (in_valid && in_ready)
                scan_byte(ch, last);
            beats_due <= token_beats_q.size();
        end
    end

endmodule

// ----- verif/command_line_tokenizer_tb.sv -----
// Testbench top for the command line tokenizer: clock, reset, APB writes, byte stimulus,
// result back-pressure, watchdog and verdict. Depends on ct_pkg, the RTL top
// and command_line_tokenizer_checker, which does all prediction and comparison.

module command_line_tokenizer_tb;
    import ct_pkg::*;

    localparam int         MAX_TOKENS     = 1024;
    localparam logic [2:0] REG_MAX_TOKENS = 3'd0;
    // longest run of cycles with no beat on any channel; the long receiver
    // hold-off is the longest quiet stretch, everything else is shorter
    localparam int         STALL_LIMIT    = 2000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         SETTLE_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = 8'h20;
    logic        last = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  token_byte;
    logic [9:0]  token_index;
    logic [10:0] token_count;
    logic        last_of_run;

    int          beats_due;
    int          fail_total;

    // sender burst bookkeeping and the line being assembled
    int          burst_left = 0;
    logic [7:0]  line_q[$];
    // raised by the stimulus, cleared by the receiver when it starts holding off
    logic        hold_req = 1'b0;

    command_line_tokenizer #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .token_byte  (token_byte),
        .token_index (token_index),
        .token_count (token_count),
        .last_of_run (last_of_run)
    );

    command_line_tokenizer_checker #(
        .MAX_TOKENS (MAX_TOKENS),
        .LIMIT_ADDR (REG_MAX_TOKENS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .token_byte  (token_byte),
        .token_index (token_index),
        .token_count (token_count),
        .last_of_run (last_of_run),
        .beats_due   (beats_due),
        .fail_total  (fail_total)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Byte classes for building command lines
    // ------------------------------------------------------------------

    // non-separator token byte; quote and slash have meanings of their own
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h21, 8'h7F));
        while (c == CH_QUOTE || c == CH_SLASH);
        return c;
    endfunction

    // separator: space, control bytes, or the top half (signed char)
    function automatic logic [7:0] gap_char();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return 8'($urandom_range(8'h01, 8'h20));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(8'h01, 8'hFF));
    endfunction

    // body bytes of a block comment, biased toward star and slash so that
    // near-miss closers and stray stars get exercised
    function automatic logic [7:0] comment_char();
        case ($urandom_range(0, 3))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return word_char();
            default: return any_char();
        endcase
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    // One random line: mostly well-formed pieces (words, separators, quoted
    // strings, comments) with some loose slashes and raw noise mixed in.
    function automatic void build_line();
        int parts;
        int sel;
        int n;
        logic [7:0] c;
        parts = $urandom_range(1, 7);
        repeat (parts)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                n = $urandom_range(1, 6);
                repeat (n) line_q.push_back(word_char());
            end
            else if (sel < 55)
            begin
                n = $urandom_range(1, 3);
                repeat (n) line_q.push_back(gap_char());
            end
            else if (sel < 70)
            begin
                // quoted token, sometimes left open
                line_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    do
                        c = any_char();
                    while (c == CH_QUOTE);
                    line_q.push_back(c);
                end
                if ($urandom_range(0, 6) != 0)
                    line_q.push_back(CH_QUOTE);
            end
            else if (sel < 77)
            begin
                add_text("//");
                n = $urandom_range(0, 6);
                repeat (n) line_q.push_back(any_char());
            end
            else if (sel < 88)
            begin
                add_text("/*");
                if ($urandom_range(0, 4) == 0)
                    line_q.push_back(CH_SLASH);
                else
                begin
                    n = $urandom_range(0, 6);
                    repeat (n) line_q.push_back(comment_char());
                    if ($urandom_range(0, 4) != 0)
                        add_text("*/");
                end
            end
            else if (sel < 94)
                line_q.push_back(CH_SLASH);
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) line_q.push_back(any_char());
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // One byte beat. The sender runs in bursts; between bursts valid drops for
    // a random gap, and a third of the bursts follow on with no gap at all.
    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 8);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    // random lines until at least n_bytes beats have gone in
    task automatic run_phase(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_line();
            sent += line_q.size();
            send_line();
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the block before touching the register: stop the sender, wait
    // until every predicted beat has come out, then idle for SETTLE_CYCLES.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [10:0] value);
        quiesce();
        write_reg(REG_MAX_TOKENS, 32'(value));
    endtask

    // ------------------------------------------------------------------
    // Receiver: changes its stall style after each random span. Styles are
    // always ready, mostly ready, mostly stalled, and periodically ready.
    // On request it holds off for a long stretch while the sender keeps
    // offering bytes, so the result register fills and in_ready drops.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int style;
        int span;
        int k;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 96);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= (k % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: any beat on the byte, result or register channel counts as
    // progress; a long silence means the block has hung.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset limit of 1024.
        // Control-byte separator, token byte 0x7F, a quote ending a plain
        // token, an empty quoted token, and a held slash at end of line.
        line_q.push_back(8'h01);
        add_text("a");
        line_q.push_back(8'h7F);
        add_text("\"\"/");
        send_line();
        // slash inside a word, then a line comment cutting the word short
        add_text("b/e//c");
        send_line();
        // slash-star-slash closes at once; 0xFF separates; quote open at end
        add_text("/*/d");
        line_q.push_back(8'hFF);
        add_text("\"e");
        send_line();
        // block comment opened by a word and left open at end of line
        add_text("f/*x");
        send_line();
        // lone slash between tokens starts a plain token
        add_text("/g");
        send_line();

        // Limit of one: everything after the first token is ignored.
        set_limit(11'd1);
        run_phase(80);

        set_limit(11'd3);
        run_phase(90);

        // Largest limit, with the long receiver hold-off during this phase.
        set_limit(11'd1024);
        hold_req = 1'b1;
        run_phase(100);

        set_limit(11'($urandom_range(2, 6)));
        run_phase(90);

        // all low bits of the register set
        set_limit(11'd1023);
        run_phase(85);

        quiesce();
        if (fail_total == 0 && beats_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ct_pkg.sv
rtl/ct_step.sv
rtl/ct_outq.sv
rtl/command_line_tokenizer.sv
verif/command_line_tokenizer_checker.sv
verif/command_line_tokenizer_tb.sv
